[rtl/assert_macros.svh]
// assertion macros used by packet_rate_statistics.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PRS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/prs_pkg.sv]
// shared constants and types of the packet rate statistics block
package prs_pkg;

  // microseconds per second, used as the rate scale
  localparam int unsigned SCALE_W  = 20;
  localparam logic [SCALE_W-1:0] SCALE = 20'd1000000;
  localparam int unsigned SCALE_IW = 5;

  // operand, product and iteration counter widths of the scaled divider
  localparam int unsigned OPND_W = 64;
  localparam int unsigned PROD_W = OPND_W + SCALE_W;
  localparam int unsigned CNT_W  = 7;

  // sampling window register
  localparam int unsigned WIN_W = 16;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd50;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } prs_div_stat_t;

endpackage

[rtl/prs_scaled_div.sv]
// shared unit: floor(num * 1e6 / den) by shift-add multiply then restoring divide
module prs_scaled_div import prs_pkg::*; #(
  parameter int unsigned RATE_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OPND_W-1:0] num,
  input  logic [OPND_W-1:0] den,
  output prs_div_stat_t     stat,
  output logic [RATE_W-1:0] quot
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_DIV  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [OPND_W-1:0] rem_r, rem_nxt;
  logic [OPND_W-1:0] num_r, den_r;

  logic [OPND_W:0]   shifted;
  logic [OPND_W+1:0] diff;
  logic              ge;
  logic              sat;

  // one restoring divide step: bring down the top product bit
  assign shifted = {rem_r, prod_r[PROD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = ~diff[OPND_W+1];

  // sequencer and datapath next values
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          state_nxt = D_MUL;
          cnt_nxt   = CNT_W'(SCALE_W - 1);
          prod_nxt  = '0;
          rem_nxt   = '0;
        end
      end
      D_MUL: begin
        // msb-first shift-add of the scale constant
        prod_nxt = {prod_r[PROD_W-2:0], 1'b0}
                 + (SCALE[cnt_r[SCALE_IW-1:0]] ? {{SCALE_W{1'b0}}, num_r} : '0);
        if (cnt_r == '0) begin
          state_nxt = D_DIV;
          cnt_nxt   = CNT_W'(PROD_W - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      D_DIV: begin
        // quotient bits shift in where product bits leave
        rem_nxt  = ge ? diff[OPND_W-1:0] : shifted[OPND_W-1:0];
        prod_nxt = {prod_r[PROD_W-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = D_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    if (state_r == D_IDLE && start) begin
      num_r <= num;
      den_r <= den;
    end
  end

  // saturate quotients that do not fit the rate width
  assign sat  = |prod_r[PROD_W-1:RATE_W];
  assign quot = sat ? {RATE_W{1'b1}} : prod_r[RATE_W-1:0];

  assign stat.busy = (state_r != D_IDLE);
  assign stat.done = done_r;

endmodule

[rtl/packet_rate_statistics.sv]
// top level of the packet rate statistics block
// Each accepted packet updates the running totals and window sums in the
// cycle it is accepted, and the block is ready again on the next cycle when
// the window is not yet full. The packet that fills the window starts four
// rate computations (window packet rate, window byte rate, average packet
// rate, average byte rate) on one shared scaled divider: each scales by one
// million with shift-add steps and then runs a restoring divide, around a
// start state and a wait state in the sequencer that takes the quotient.
// The closing packet keeps the input closed until the result is loaded into
// the output register, which takes longer while an earlier result still
// waits there. The output register lets the next packet enter while a
// result is still waiting to be taken. A zero time divisor or a quotient
// that does not fit RATE_WIDTH bits gives all ones; a sampling window of
// zero acts as one.
`include "assert_macros.svh"

module packet_rate_statistics import prs_pkg::*; #(
  parameter int unsigned RATE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [WIN_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_elapsed_us,
  input  logic [15:0]           in_packet_len,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [47:0]           out_packets_seen,
  output logic [RATE_WIDTH-1:0] out_rate_average,
  output logic [RATE_WIDTH-1:0] out_rate_lowest,
  output logic [RATE_WIDTH-1:0] out_throughput_average,
  output logic [RATE_WIDTH-1:0] out_throughput_lowest
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_START  = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [1:0] OP_WRATE = 2'd0;
  localparam logic [1:0] OP_WTHRU = 2'd1;
  localparam logic [1:0] OP_ARATE = 2'd2;
  localparam logic [1:0] OP_ATHRU = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [WIN_W-1:0]      window_cfg_r;
  logic [47:0]           packet_total_r;
  logic [63:0]           byte_total_r;
  logic [47:0]           window_bytes_r;
  logic [63:0]           time_total_r;
  logic [63:0]           window_time_r;
  logic [WIN_W-1:0]      window_count_r;
  logic [RATE_WIDTH-1:0] rate_worst_r;
  logic [RATE_WIDTH-1:0] thru_worst_r;
  logic [RATE_WIDTH-1:0] rate_avg_r;
  logic [RATE_WIDTH-1:0] thru_avg_r;
  logic                  out_valid_r;

  logic                  accept;
  logic [WIN_W-1:0]      limit;
  logic [WIN_W-1:0]      count_inc;
  logic                  close;
  logic                  load_out;
  logic                  div_start;
  logic [OPND_W-1:0]     div_num, div_den;
  logic [RATE_WIDTH-1:0] div_quot;
  prs_div_stat_t         div_stat;

  // request handshake and window close test
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign limit     = (window_cfg_r == '0) ? WIN_W'(1) : window_cfg_r;
  assign count_inc = window_count_r + 1'b1;
  assign close     = (count_inc >= limit);
  assign load_out  = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign div_start = (state_r == S_START);

  // sequencer over the four rate computations
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && close) begin
          state_nxt = S_START;
          op_nxt    = OP_WRATE;
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_stat.done) begin
          if (op_r == OP_ATHRU) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_START;
            op_nxt    = op_r + 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // divider operand selection
  always_comb begin
    unique case (op_r)
      OP_WRATE: begin
        div_num = {{(OPND_W-WIN_W){1'b0}}, window_count_r};
        div_den = window_time_r;
      end
      OP_WTHRU: begin
        div_num = {16'b0, window_bytes_r};
        div_den = window_time_r;
      end
      OP_ARATE: begin
        div_num = {16'b0, packet_total_r};
        div_den = time_total_r;
      end
      OP_ATHRU: begin
        div_num = byte_total_r;
        div_den = time_total_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  prs_scaled_div #(
    .RATE_W (RATE_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // control, configuration and accumulated state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      op_r           <= OP_WRATE;
      window_cfg_r   <= WIN_RESET;
      packet_total_r <= '0;
      byte_total_r   <= '0;
      window_bytes_r <= '0;
      time_total_r   <= '0;
      window_time_r  <= '0;
      window_count_r <= '0;
      rate_worst_r   <= '0;
      thru_worst_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (cfg_wr_en) begin
        window_cfg_r <= cfg_wr_data;
      end
      // per-packet accumulation, every sum wraps at its width
      if (accept) begin
        packet_total_r <= packet_total_r + 1'b1;
        byte_total_r   <= byte_total_r + {48'b0, in_packet_len};
        window_bytes_r <= window_bytes_r + {32'b0, in_packet_len};
        time_total_r   <= time_total_r + {32'b0, in_elapsed_us};
        window_time_r  <= window_time_r + {32'b0, in_elapsed_us};
        window_count_r <= count_inc;
      end
      // lowest window rates, zero counts as unset
      if (state_r == S_WAIT && div_stat.done) begin
        if (op_r == OP_WRATE && (rate_worst_r == '0 || rate_worst_r > div_quot)) begin
          rate_worst_r <= div_quot;
        end
        if (op_r == OP_WTHRU && (thru_worst_r == '0 || thru_worst_r > div_quot)) begin
          thru_worst_r <= div_quot;
        end
      end
      // window sums restart once the result is loaded
      if (load_out) begin
        window_bytes_r <= '0;
        window_time_r  <= '0;
        window_count_r <= '0;
      end
      // output register valid
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // average rates captured from the divider
  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && div_stat.done) begin
      if (op_r == OP_ARATE) begin
        rate_avg_r <= div_quot;
      end
      if (op_r == OP_ATHRU) begin
        thru_avg_r <= div_quot;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_packets_seen       <= packet_total_r;
      out_rate_average       <= rate_avg_r;
      out_rate_lowest        <= rate_worst_r;
      out_throughput_average <= thru_avg_r;
      out_throughput_lowest  <= thru_worst_r;
    end
  end

  assign out_valid = out_valid_r;

  // divider finishes only while the sequencer waits for it
  `PRS_ASSERT_IMPL(a_done_in_wait, clk, rst_n, div_stat.done, state_r == S_WAIT)
  // a new computation never starts on a busy divider
  `PRS_ASSERT_IMPL(a_start_idle, clk, rst_n, div_start, !div_stat.busy)
  // a request that fills the window starts the rate sequence
  `PRS_ASSERT_NEXT(a_close_starts, clk, rst_n, accept && close, state_r == S_START)

endmodule
